// File: rtl/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RRQS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RRQS_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define RRQS_ASSERT(lbl, clk, rst, prop, msg)
`define RRQS_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// File: rtl/rrqs_pkg.sv
// Types and constants of the round-robin quantum scheduler.
`default_nettype none
package rrqs_pkg;
  localparam int SlotW  = 9;
  localparam int KindW  = 2;
  localparam int ActW   = 2;
  localparam int LiveW  = 10;
  localparam int QuantW = 7;

  localparam logic [KindW-1:0] KIND_TICK  = 2'd0;
  localparam logic [KindW-1:0] KIND_ADMIT = 2'd1;
  localparam logic [KindW-1:0] KIND_EXIT  = 2'd2;

  localparam logic [ActW-1:0] ACT_STOP   = 2'd0;
  localparam logic [ActW-1:0] ACT_FIRST  = 2'd1;
  localparam logic [ActW-1:0] ACT_RESUME = 2'd2;

  typedef logic [QuantW-1:0] quantum_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [SlotW-1:0] slot;
  } evt_t;

  typedef struct packed {
    logic [ActW-1:0]  action;
    logic [SlotW-1:0] task_slot;
    logic [LiveW-1:0] live_tasks;
    logic             last;
  } act_t;

  typedef struct packed {
    logic valid;
    act_t data;
  } emit_t;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic [SlotW-1:0] wdata;
  } qctl_t;

  typedef struct packed {
    logic             empty;
    logic             full;
    logic [SlotW-1:0] rdata;
  } qstat_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_QRD,
    S_FRD,
    S_OUT
  } state_t;
endpackage
`default_nettype wire

// File: rtl/rrqs_stream_if.sv
// Valid/ready channel interface with a typed payload.
`default_nettype none
interface rrqs_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/rrqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rrqs_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/rrqs_queue.sv
// Ring-buffer run queue: pointers, count and the entry RAM.
`default_nettype none
`include "assert_macros.svh"
module rrqs_queue #(
  parameter int DEPTH = 512
) (
  input  logic           clk,
  input  logic           rst,
  input  rrqs_pkg::qctl_t  qctl,
  output rrqs_pkg::qstat_t qst
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [CW-1:0] Full = CW'(DEPTH);

  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [CW-1:0] count;
  logic [rrqs_pkg::SlotW-1:0] rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (qctl.push) begin
        tail <= (tail == LastIdx) ? '0 : tail + AW'(1);
      end
      if (qctl.pop) begin
        head <= (head == LastIdx) ? '0 : head + AW'(1);
      end
      case ({qctl.push, qctl.pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  rrqs_ram #(.WIDTH(rrqs_pkg::SlotW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (qctl.push),
    .waddr (tail),
    .wdata (qctl.wdata),
    .raddr (head),
    .rdata (rdata)
  );

  assign qst.empty = (count == '0);
  assign qst.full  = (count == Full);
  assign qst.rdata = rdata;

  `RRQS_ASSERT_NEVER(a_push_full, clk, rst, qctl.push && qst.full, "push into full queue")
  `RRQS_ASSERT_NEVER(a_pop_empty, clk, rst, qctl.pop && qst.empty, "pop from empty queue")
  `RRQS_ASSERT(a_empty_ptrs, clk, rst, qst.empty |-> (head == tail), "empty queue, pointers differ")
endmodule
`default_nettype wire

// File: rtl/rrqs_ctrl.sv
// Scheduler sequencer: slot flag RAM, current task state and event handling.
`default_nettype none
`include "assert_macros.svh"
module rrqs_ctrl #(
  parameter int MAX_TASKS = 512
) (
  input  logic                clk,
  input  logic                rst,
  input  rrqs_pkg::quantum_t  quantum,
  rrqs_stream_if.sink         evt,
  input  logic                out_free,
  output rrqs_pkg::emit_t     emit,
  output rrqs_pkg::qctl_t     qctl,
  input  rrqs_pkg::qstat_t    qst
);
  localparam int SW = rrqs_pkg::SlotW;
  localparam int AW = $clog2(MAX_TASKS);
  localparam int XW = ((AW > SW) ? AW : SW) + 1;
  localparam logic [XW-1:0] Limit = XW'(MAX_TASKS);
  localparam logic [AW-1:0] LastIdx = AW'(MAX_TASKS - 1);

  rrqs_pkg::state_t state;
  rrqs_pkg::state_t state_next;

  logic [rrqs_pkg::KindW-1:0]  kind_r;
  logic [SW-1:0]               slot_r;
  logic [SW-1:0]               cur_slot;
  logic                        cur_valid;
  logic [rrqs_pkg::QuantW-1:0] ticks_left;
  logic [rrqs_pkg::LiveW-1:0]  live_count;
  logic                        pend_stop;
  logic                        have_start;
  logic [rrqs_pkg::ActW-1:0]   start_act;
  logic [SW-1:0]               stop_slot;
  logic [SW-1:0]               cand_r;
  logic [AW-1:0]               clr_addr;

  logic [XW-1:0] in_x, slot_x, cur_x, cand_x, qd_x;
  logic          slot_ok, cur_ok, cand_ok;

  logic          f_we;
  logic [AW-1:0] f_waddr;
  logic [1:0]    f_wdata;
  logic [AW-1:0] f_raddr;
  logic [1:0]    f_rdata;

  assign in_x    = XW'(evt.data.slot);
  assign slot_x  = XW'(slot_r);
  assign cur_x   = XW'(cur_slot);
  assign cand_x  = XW'(cand_r);
  assign qd_x    = XW'(qst.rdata);
  assign slot_ok = (slot_x < Limit);
  assign cur_ok  = (cur_x < Limit);
  assign cand_ok = (cand_x < Limit);

  // flag bit 1: alive, bit 0: never started
  rrqs_ram #(.WIDTH(2), .DEPTH(MAX_TASKS)) u_flags (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrqs_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    evt.ready  = 1'b0;
    f_we       = 1'b0;
    f_waddr    = slot_x[AW-1:0];
    f_wdata    = 2'b00;
    f_raddr    = cur_x[AW-1:0];
    qctl       = '0;
    qctl.wdata = slot_r;
    emit       = '0;
    case (state)
      rrqs_pkg::S_CLEAR: begin
        f_we    = 1'b1;
        f_waddr = clr_addr;
        if (clr_addr == LastIdx) begin
          state_next = rrqs_pkg::S_IDLE;
        end
      end
      rrqs_pkg::S_IDLE: begin
        evt.ready = 1'b1;
        f_raddr   = (evt.data.kind == rrqs_pkg::KIND_TICK) ? cur_x[AW-1:0] : in_x[AW-1:0];
        if (evt.valid) begin
          state_next = rrqs_pkg::S_LOOK;
        end
      end
      rrqs_pkg::S_LOOK: begin
        state_next = rrqs_pkg::S_IDLE;
        case (kind_r)
          rrqs_pkg::KIND_ADMIT: begin
            if (slot_ok && !qst.full) begin
              f_we      = 1'b1;
              f_wdata   = 2'b11;
              qctl.push = 1'b1;
            end
          end
          rrqs_pkg::KIND_EXIT: begin
            if (slot_ok && f_rdata[1]) begin
              f_we    = 1'b1;
              f_wdata = {1'b0, f_rdata[0]};
            end
          end
          rrqs_pkg::KIND_TICK: begin
            state_next = rrqs_pkg::S_SCAN;
            if (cur_valid && cur_ok && f_rdata[1]) begin
              if (ticks_left > rrqs_pkg::QuantW'(1)) begin
                state_next = rrqs_pkg::S_IDLE;
              end else begin
                qctl.push  = !qst.full;
                qctl.wdata = cur_slot;
              end
            end
          end
          default: state_next = rrqs_pkg::S_IDLE;
        endcase
      end
      rrqs_pkg::S_SCAN: begin
        if (qst.empty) begin
          state_next = pend_stop ? rrqs_pkg::S_OUT : rrqs_pkg::S_IDLE;
        end else begin
          qctl.pop   = 1'b1;
          state_next = rrqs_pkg::S_QRD;
        end
      end
      rrqs_pkg::S_QRD: begin
        f_raddr    = qd_x[AW-1:0];
        state_next = rrqs_pkg::S_FRD;
      end
      rrqs_pkg::S_FRD: begin
        if (cand_ok && f_rdata[1]) begin
          f_we       = 1'b1;
          f_waddr    = cand_x[AW-1:0];
          f_wdata    = 2'b10;
          state_next = rrqs_pkg::S_OUT;
        end else begin
          state_next = rrqs_pkg::S_SCAN;
        end
      end
      rrqs_pkg::S_OUT: begin
        if (out_free) begin
          emit.valid           = 1'b1;
          emit.data.live_tasks = live_count;
          if (pend_stop) begin
            emit.data.action    = rrqs_pkg::ACT_STOP;
            emit.data.task_slot = stop_slot;
            emit.data.last      = !have_start;
            if (!have_start) begin
              state_next = rrqs_pkg::S_IDLE;
            end
          end else begin
            emit.data.action    = start_act;
            emit.data.task_slot = cur_slot;
            emit.data.last      = 1'b1;
            state_next          = rrqs_pkg::S_IDLE;
          end
        end
      end
      default: state_next = rrqs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_slot   <= '0;
      cur_valid  <= 1'b0;
      ticks_left <= '0;
      live_count <= '0;
      pend_stop  <= 1'b0;
      have_start <= 1'b0;
      clr_addr   <= '0;
    end else begin
      case (state)
        rrqs_pkg::S_CLEAR: clr_addr <= clr_addr + AW'(1);
        rrqs_pkg::S_IDLE: begin
          if (evt.valid) begin
            kind_r     <= evt.data.kind;
            slot_r     <= evt.data.slot;
            pend_stop  <= 1'b0;
            have_start <= 1'b0;
          end
        end
        rrqs_pkg::S_LOOK: begin
          case (kind_r)
            rrqs_pkg::KIND_ADMIT: begin
              if (slot_ok && !qst.full && !f_rdata[1]) begin
                live_count <= live_count + rrqs_pkg::LiveW'(1);
              end
            end
            rrqs_pkg::KIND_EXIT: begin
              if (slot_ok && f_rdata[1] && live_count != '0) begin
                live_count <= live_count - rrqs_pkg::LiveW'(1);
              end
            end
            rrqs_pkg::KIND_TICK: begin
              if (cur_valid) begin
                if (cur_ok && f_rdata[1]) begin
                  if (ticks_left > rrqs_pkg::QuantW'(1)) begin
                    ticks_left <= ticks_left - rrqs_pkg::QuantW'(1);
                  end else begin
                    ticks_left <= '0;
                    pend_stop  <= 1'b1;
                    stop_slot  <= cur_slot;
                    cur_valid  <= 1'b0;
                  end
                end else begin
                  cur_valid <= 1'b0;
                end
              end
            end
            default: ;
          endcase
        end
        rrqs_pkg::S_QRD: cand_r <= qst.rdata;
        rrqs_pkg::S_FRD: begin
          if (cand_ok && f_rdata[1]) begin
            cur_slot   <= cand_r;
            cur_valid  <= 1'b1;
            ticks_left <= quantum;
            have_start <= 1'b1;
            start_act  <= f_rdata[0] ? rrqs_pkg::ACT_FIRST : rrqs_pkg::ACT_RESUME;
          end
        end
        rrqs_pkg::S_OUT: begin
          if (out_free && pend_stop) begin
            pend_stop <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  `RRQS_ASSERT(a_emit_free, clk, rst, emit.valid |-> out_free, "result with output busy")
  `RRQS_ASSERT(a_out_pending, clk, rst, (state == rrqs_pkg::S_OUT) |-> (pend_stop || have_start), "output state with nothing to send")
  `RRQS_ASSERT(a_clear_after_rst, clk, rst, $fell(rst) |-> (state == rrqs_pkg::S_CLEAR), "no flag clear after reset")
endmodule
`default_nettype wire

// File: rtl/round_robin_quantum_scheduler_top.sv
// Round-robin quantum scheduler: top level with config and output registers.
// Admit, exit, unknown events and a tick that only counts down pass idle and look only.
// Other ticks then scan the run queue, each entry examined by a queue RAM read, then
// a flag RAM read, until a live entry is found, and send each result through the output state.
// Reset clears the slot flag RAM entry by entry while events wait; quantum resets to 1.
// One event in flight at a time; config writes are taken at any time.
`default_nettype none
module round_robin_quantum_scheduler_top #(
  parameter int MAX_TASKS = 512
) (
  input  logic          clk,
  input  logic          rst,
  rrqs_stream_if.sink   cfg,
  rrqs_stream_if.sink   evt,
  rrqs_stream_if.source act
);
  rrqs_pkg::quantum_t quantum;
  rrqs_pkg::emit_t    emit;
  rrqs_pkg::qctl_t    qctl;
  rrqs_pkg::qstat_t   qst;
  rrqs_pkg::act_t     out_data;
  logic               out_valid;
  logic               out_free;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= rrqs_pkg::QuantW'(1);
    end else if (cfg.valid) begin
      quantum <= cfg.data;
    end
  end

  assign out_free = !out_valid || act.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.valid) begin
      out_valid <= 1'b1;
    end else if (act.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_data <= emit.data;
    end
  end

  assign act.valid = out_valid;
  assign act.data  = out_data;

  rrqs_queue #(.DEPTH(MAX_TASKS)) u_queue (
    .clk  (clk),
    .rst  (rst),
    .qctl (qctl),
    .qst  (qst)
  );

  rrqs_ctrl #(.MAX_TASKS(MAX_TASKS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .quantum  (quantum),
    .evt      (evt),
    .out_free (out_free),
    .emit     (emit),
    .qctl     (qctl),
    .qst      (qst)
  );
endmodule
`default_nettype wire

// File: sim/round_robin_quantum_scheduler_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the round-robin quantum scheduler top level.
module round_robin_quantum_scheduler_top_test;
  localparam int SW = rrqs_pkg::SlotW;
  localparam int KW = rrqs_pkg::KindW;
  localparam int LW = rrqs_pkg::LiveW;
  localparam int SLOTS = 512;
  localparam int SETTLE_CYCLES = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [KW-1:0] KIND_UNKNOWN = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rrqs_stream_if #(.T(rrqs_pkg::quantum_t)) cfg_if ();
  rrqs_stream_if #(.T(rrqs_pkg::evt_t))     evt_if ();
  rrqs_stream_if #(.T(rrqs_pkg::act_t))     act_if ();

  round_robin_quantum_scheduler_top #(.MAX_TASKS(SLOTS)) dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_if),
    .evt(evt_if),
    .act(act_if)
  );

  always #4 clk = ~clk;

  // scheduler state mirror
  logic [SW-1:0]        run_q [SLOTS];
  int unsigned          q_head;
  int unsigned          q_tail;
  int unsigned          q_count;
  bit                   alive [SLOTS];
  bit                   fresh [SLOTS];
  logic [SW-1:0]        cur_slot = '0;
  bit                   cur_valid;
  rrqs_pkg::quantum_t   ticks_left = '0;
  rrqs_pkg::quantum_t   quantum = 7'd1;
  logic [LW-1:0]        live_count = '0;

  rrqs_pkg::act_t pending_actions[$];
  rrqs_pkg::act_t got_act;
  rrqs_pkg::act_t want_act;
  int   fail_count;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_requests;
  int   holds_done;

  function automatic void enqueue_slot(input logic [SW-1:0] s);
    if (q_count < SLOTS) begin
      run_q[q_tail] = s;
      q_tail = (q_tail + 1) % SLOTS;
      q_count++;
    end
  endfunction

  function automatic void schedule_event(input rrqs_pkg::evt_t e);
    rrqs_pkg::act_t outs [2];
    int             n;
    logic [SW-1:0]  s;
    n = 0;
    case (e.kind)
      rrqs_pkg::KIND_ADMIT: begin
        if (q_count < SLOTS) begin
          if (!alive[e.slot]) live_count++;
          alive[e.slot] = 1'b1;
          fresh[e.slot] = 1'b1;
          enqueue_slot(e.slot);
        end
      end
      rrqs_pkg::KIND_EXIT: begin
        if (alive[e.slot]) begin
          alive[e.slot] = 1'b0;
          if (live_count > 0) live_count--;
        end
      end
      rrqs_pkg::KIND_TICK: begin
        if (cur_valid && alive[cur_slot] && ticks_left > 1) begin
          ticks_left--;
        end else begin
          if (cur_valid && alive[cur_slot]) begin
            ticks_left = '0;
            outs[n] = '{action: rrqs_pkg::ACT_STOP, task_slot: cur_slot,
                        live_tasks: live_count, last: 1'b0};
            n++;
            enqueue_slot(cur_slot);
          end
          cur_valid = 1'b0;
          while (q_count > 0 && !cur_valid) begin
            s = run_q[q_head];
            q_head = (q_head + 1) % SLOTS;
            q_count--;
            if (alive[s]) begin
              cur_slot = s;
              cur_valid = 1'b1;
              ticks_left = quantum;
              outs[n] = '{action: fresh[s] ? rrqs_pkg::ACT_FIRST : rrqs_pkg::ACT_RESUME,
                          task_slot: s, live_tasks: live_count, last: 1'b0};
              fresh[s] = 1'b0;
              n++;
            end
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < n; i++) begin
      outs[i].last = (i == n - 1);
      pending_actions.push_back(outs[i]);
    end
  endfunction

  task automatic post_event(input logic [KW-1:0] kind, input logic [SW-1:0] slot);
    rrqs_pkg::evt_t e;
    e.kind = kind;
    e.slot = slot;
    while ($urandom_range(99) < send_idle_pct) begin
      evt_if.valid <= 1'b0;
      @(posedge clk);
    end
    evt_if.valid <= 1'b1;
    evt_if.data <= e;
    @(posedge clk);
    while (!evt_if.ready) @(posedge clk);
    schedule_event(e);
  endtask

  task automatic wait_for_quiet(input int settle);
    evt_if.valid <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_quantum(input rrqs_pkg::quantum_t q);
    wait_for_quiet(SETTLE_CYCLES);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= q;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    quantum = q;
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 32;
    recv_idle_pct = 74;
    post_event(rrqs_pkg::KIND_TICK, 9'd511);
    post_event(KIND_UNKNOWN, 9'd0);
    post_event(rrqs_pkg::KIND_EXIT, 9'd5);
    post_event(rrqs_pkg::KIND_ADMIT, 9'd0);
    post_event(rrqs_pkg::KIND_ADMIT, 9'd511);
    post_event(rrqs_pkg::KIND_ADMIT, 9'd0);
    post_event(rrqs_pkg::KIND_TICK, 9'd0);
    post_event(rrqs_pkg::KIND_TICK, 9'd0);
    post_event(rrqs_pkg::KIND_TICK, 9'd0);
    post_event(rrqs_pkg::KIND_EXIT, 9'd0);
    // current task exited: dropped without a stop
    post_event(rrqs_pkg::KIND_TICK, 9'd0);
    post_event(rrqs_pkg::KIND_EXIT, 9'd511);
    post_event(rrqs_pkg::KIND_TICK, 9'h1AA);
    post_event(rrqs_pkg::KIND_TICK, 9'h155);
    set_quantum('0);
    post_event(rrqs_pkg::KIND_ADMIT, 9'd3);
    post_event(rrqs_pkg::KIND_TICK, 9'd0);
    post_event(rrqs_pkg::KIND_TICK, 9'd0);
    set_quantum(7'd100);
    post_event(rrqs_pkg::KIND_ADMIT, 9'd4);
    repeat (4) post_event(rrqs_pkg::KIND_TICK, 9'd0);
    post_event(rrqs_pkg::KIND_EXIT, 9'd3);
    post_event(rrqs_pkg::KIND_EXIT, 9'd4);
    post_event(rrqs_pkg::KIND_TICK, 9'd511);
  endtask

  task automatic test_queue_overflow();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_quantum(7'd1);
    post_event(rrqs_pkg::KIND_ADMIT, 9'd300);
    post_event(rrqs_pkg::KIND_TICK, 9'd0);
    while (q_count < SLOTS) post_event(rrqs_pkg::KIND_ADMIT, SW'($urandom_range(7)));
    post_event(rrqs_pkg::KIND_ADMIT, 9'd9);
    post_event(rrqs_pkg::KIND_EXIT, 9'd9);
    // stopped task cannot be queued again
    post_event(rrqs_pkg::KIND_TICK, 9'd0);
    for (int s = 0; s < SLOTS; s++) begin
      if (alive[s]) post_event(rrqs_pkg::KIND_EXIT, SW'(s));
    end
    // long scan over dead entries
    post_event(rrqs_pkg::KIND_TICK, 9'd0);
    post_event(rrqs_pkg::KIND_TICK, 9'd0);
    post_event(rrqs_pkg::KIND_ADMIT, 9'd511);
    post_event(rrqs_pkg::KIND_TICK, 9'd0);
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_quantum(7'd1);
    post_event(rrqs_pkg::KIND_ADMIT, 9'd1);
    post_event(rrqs_pkg::KIND_ADMIT, 9'd2);
    post_event(rrqs_pkg::KIND_ADMIT, 9'd3);
    hold_requests++;
    repeat (40) post_event(rrqs_pkg::KIND_TICK, SW'($urandom_range(511)));
    wait_for_quiet(0);
    repeat (6) post_event(rrqs_pkg::KIND_TICK, SW'($urandom_range(511)));
  endtask

  task automatic test_random_traffic(input int items, input int sidle, input int ridle,
                                     input rrqs_pkg::quantum_t q);
    int            r;
    logic [SW-1:0] s;
    set_quantum(q);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    repeat (items) begin
      r = $urandom_range(99);
      if ($urandom_range(99) < 85) s = SW'($urandom_range(15));
      else s = SW'($urandom_range(511));
      if (r < 48) post_event(rrqs_pkg::KIND_TICK, SW'($urandom_range(511)));
      else if (r < 73) post_event(rrqs_pkg::KIND_ADMIT, s);
      else if (r < 95) post_event(rrqs_pkg::KIND_EXIT, s);
      else post_event(KIND_UNKNOWN, SW'($urandom_range(511)));
    end
  endtask

  initial begin
    act_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        act_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        act_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && act_if.valid && act_if.ready) begin
      got_act = act_if.data;
      if (pending_actions.size() == 0) begin
        $error("unexpected transaction: action %0d slot %0d", got_act.action,
               got_act.task_slot);
        fail_count++;
      end else begin
        want_act = pending_actions.pop_front();
        if (got_act.action !== want_act.action) begin
          $error("action: expected %0d, got %0d", want_act.action, got_act.action);
          fail_count++;
        end
        if (got_act.task_slot !== want_act.task_slot) begin
          $error("task_slot: expected %0d, got %0d", want_act.task_slot, got_act.task_slot);
          fail_count++;
        end
        if (got_act.live_tasks !== want_act.live_tasks) begin
          $error("live_tasks: expected %0d, got %0d", want_act.live_tasks,
                 got_act.live_tasks);
          fail_count++;
        end
        if (got_act.last !== want_act.last) begin
          $error("last: expected %0d, got %0d", want_act.last, got_act.last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    evt_if.valid <= 1'b0;
    evt_if.data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_queue_overflow();
    test_output_backpressure();
    test_random_traffic(420, 32, 74, 7'd2);
    test_random_traffic(420, 74, 32, rrqs_pkg::quantum_t'($urandom_range(1, 6)));
    test_random_traffic(420, 0, 0, 7'd1);
    wait_for_quiet(SETTLE_CYCLES);
    if (fail_count == 0 && pending_actions.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule
